@@ rtl/core/dee_pkg.sv @@
package dee_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned DiffW      = WordW + 1;
  localparam int unsigned RawBytes   = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;
  localparam int unsigned ByteIdxW   = 3;

  localparam logic [ByteW-1:0] EscapeByte = 8'h80;
  localparam int ShortLimit = 127;

  typedef enum logic [1:0] {
    KIND_SHORT,
    KIND_RAW,
    KIND_ESC
  } dee_kind_e;

  // One classified item waiting for serialization.
  typedef struct packed {
    dee_kind_e              kind;
    logic [WordW-1:0]       word;
    logic [ByteW-1:0]       short_byte;
  } dee_entry_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QueueCntW-1:0] count;
  } dee_q_status_t;

endpackage

@@ rtl/core/dee_front.sv @@
module dee_front
  import dee_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [WordW-1:0]   number_in_i,
  input  dee_q_status_t      q_status_i,
  output logic               push_o,
  output dee_entry_t         push_entry_o
);

  logic                    awaiting_first_q, awaiting_first_d;
  logic [WordW-1:0]        prev_q, prev_d;
  logic signed [DiffW-1:0] diff;
  logic                    is_short;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  // The difference is one bit wider than the operands, so it never wraps.
  assign diff = $signed({number_in_i[WordW-1], number_in_i})
              - $signed({prev_q[WordW-1], prev_q});
  assign is_short = (diff >= DiffW'(-ShortLimit)) && (diff <= DiffW'(ShortLimit));

  always_comb begin
    push_entry_o.word       = number_in_i;
    push_entry_o.short_byte = diff[ByteW-1:0];
    if (awaiting_first_q) begin
      push_entry_o.kind = KIND_RAW;
    end else if (is_short) begin
      push_entry_o.kind = KIND_SHORT;
    end else begin
      push_entry_o.kind = KIND_ESC;
    end
  end

  always_comb begin
    awaiting_first_d = awaiting_first_q;
    prev_d           = prev_q;
    if (push_o) begin
      awaiting_first_d = 1'b0;
      prev_d           = number_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_first_q <= 1'b1;
      prev_q           <= '0;
    end else begin
      awaiting_first_q <= awaiting_first_d;
      prev_q           <= prev_d;
    end
  end

endmodule

@@ rtl/core/dee_fifo.sv @@
module dee_fifo
  import dee_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dee_entry_t    push_entry_i,
  input  logic          pop_i,
  output dee_entry_t    head_o,
  output dee_q_status_t status_o
);

  dee_entry_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/core/dee_back.sv @@
module dee_back
  import dee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dee_entry_t        head_i,
  input  dee_q_status_t     q_status_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              last_byte_o
);

  logic                 out_valid_q, out_valid_d;
  logic [ByteW-1:0]     out_byte_q, out_byte_d;
  logic                 last_q, last_d;
  logic [ByteIdxW-1:0]  idx_q, idx_d;
  logic                 load;
  logic [1:0]           raw_sel;
  logic [ByteW-1:0]     raw_byte;
  logic [ByteW-1:0]     next_byte;
  logic                 next_last;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_q;

  // The output register takes a new byte when it is empty or being transferred.
  assign load = !out_valid_q || !out_stall_i;

  // In an escaped run the raw bytes follow the escape byte, one place later.
  assign raw_sel = (head_i.kind == KIND_ESC) ? 2'(idx_q - 1'b1) : idx_q[1:0];

  always_comb begin
    case (raw_sel)
      2'd0:    raw_byte = head_i.word[7:0];
      2'd1:    raw_byte = head_i.word[15:8];
      2'd2:    raw_byte = head_i.word[23:16];
      default: raw_byte = head_i.word[31:24];
    endcase
  end

  always_comb begin
    case (head_i.kind)
      KIND_SHORT: begin
        next_byte = head_i.short_byte;
        next_last = 1'b1;
      end
      KIND_RAW: begin
        next_byte = raw_byte;
        next_last = (idx_q == ByteIdxW'(RawBytes - 1));
      end
      KIND_ESC: begin
        next_byte = (idx_q == '0) ? EscapeByte : raw_byte;
        next_last = (idx_q == ByteIdxW'(RawBytes));
      end
      default: begin
        next_byte = head_i.short_byte;
        next_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !q_status_i.empty;
      if (!q_status_i.empty) begin
        out_byte_d = next_byte;
        last_d     = next_last;
        if (next_last) begin
          idx_d = '0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

endmodule

@@ rtl/core/delta_escape_encoder_top.sv @@
// Delta encoder with escape: each signed 32-bit number taken in becomes a run of
// bytes on the output, the last byte of each run flagged. The first number after
// reset goes out as four raw bytes, least significant first; later numbers go
// out as one two's complement byte when the difference from the previous number
// lies in -127..127, otherwise as the escape byte 0x80 and the four raw bytes.
// The front end classifies a number in the cycle it is accepted and places it in
// a two-entry queue; the back end sends one byte per cycle from the queue head
// through an output register while the output is not stalled. Input is accepted
// whenever the queue has room.
module delta_escape_encoder_top
  import dee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [WordW-1:0]  number_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              last_byte_o
);

  logic          push;
  logic          pop;
  dee_entry_t    push_entry;
  dee_entry_t    head;
  dee_q_status_t q_status;

  dee_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .number_in_i  (number_in_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  dee_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  dee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QueueCntW'(QueueDepth))
    else $error("queue count out of range");

  a_pop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && last_byte_o)
    else $error("entry retired without a flagged last byte");

endmodule
